/* src/crsf_pkg.sv */
package crsf_pkg;

  localparam int unsigned InW        = 32;
  localparam int unsigned IdxW       = 24;
  localparam int unsigned ThrW       = 16;
  localparam int unsigned SampleWDef = 32;
  localparam int unsigned QDepthDef  = 4;

  localparam logic [ThrW-1:0] ThrReset = ThrW'(4);
  localparam logic [ThrW-1:0] RunMax   = '1;

  typedef logic [IdxW-1:0] idx_t;

  typedef struct packed {
    logic a_v;
    idx_t a_start;
    idx_t a_end;
    logic b_v;
    idx_t b_start;
    idx_t b_end;
    logic last;
  } cmd_t;

  typedef struct packed {
    idx_t seg_start;
    idx_t seg_end;
    logic seg_valid;
    logic record_end;
  } seg_t;

  typedef struct packed {
    logic out_v;
    logic spill_v;
  } back_sts_t;

endpackage

/* src/crsf_in_if.sv */
interface crsf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic               last_sample;

  modport source (output valid, output sample_value, output last_sample, input ready);
  modport sink (input valid, input sample_value, input last_sample, output ready);
endinterface

/* src/crsf_out_if.sv */
interface crsf_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] seg_start;
  logic [23:0] seg_end;
  logic        seg_valid;
  logic        record_end;

  modport source (output valid, output seg_start, output seg_end, output seg_valid,
                  output record_end, input ready);
  modport sink (input valid, input seg_start, input seg_end, input seg_valid,
                input record_end, output ready);
endinterface

/* src/crsf_front.sv */
module crsf_front #(
  parameter int unsigned SampleWidth = crsf_pkg::SampleWDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [crsf_pkg::ThrW-1:0]    cfg_wdata_i,
  crsf_in_if.sink                      in_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output crsf_pkg::cmd_t               cmd_o
);
  import crsf_pkg::*;

  localparam int unsigned CmpW = (SampleWidth < InW) ? SampleWidth : InW;

  logic [ThrW-1:0] thr_q;
  logic [CmpW-1:0] held_q, held_d;
  logic [ThrW-1:0] len_q, len_d;
  idx_t            rs_q, rs_d;
  idx_t            si_q, idx;
  logic            start_q;
  logic [CmpW-1:0] smp;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;
  assign smp        = in_i.sample_value[CmpW-1:0];

  always_comb begin
    cmd_o   = '0;
    held_d  = smp;
    len_d   = ThrW'(1);
    rs_d    = '0;
    idx     = '0;
    if (start_q) begin
      idx = '0;
    end else begin
      idx = IdxW'(si_q + 1'b1);
      if (smp == held_q) begin
        held_d = held_q;
        rs_d   = rs_q;
        len_d  = (len_q == RunMax) ? len_q : ThrW'(len_q + 1'b1);
      end else begin
        cmd_o.a_v     = (len_q >= thr_q);
        cmd_o.a_start = rs_q;
        cmd_o.a_end   = IdxW'(idx - 1'b1);
        rs_d          = idx;
      end
    end
    cmd_o.last    = in_i.last_sample;
    cmd_o.b_v     = in_i.last_sample && (len_d >= thr_q);
    cmd_o.b_start = rs_d;
    cmd_o.b_end   = idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      len_q   <= '0;
      rs_q    <= '0;
      si_q    <= '0;
      start_q <= 1'b1;
    end else if (push_o) begin
      held_q  <= held_d;
      len_q   <= len_d;
      rs_q    <= rs_d;
      si_q    <= idx;
      start_q <= in_i.last_sample;
    end
  end

endmodule

/* src/crsf_queue.sv */
module crsf_queue #(
  parameter int unsigned Depth = crsf_pkg::QDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  crsf_pkg::cmd_t              cmd_i,
  output logic                        full_o,
  output logic                        valid_o,
  input  logic                        pop_i,
  output crsf_pkg::cmd_t              cmd_o,
  output logic [$clog2(Depth+1)-1:0]  cnt_o
);
  import crsf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rp_q];
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wp_q + 1'b1);
      end
      if (pop_i) begin
        rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rp_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (pop_i && !push_i) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

endmodule

/* src/crsf_back.sv */
module crsf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  crsf_pkg::cmd_t       cmd_i,
  output logic                 pop_o,
  crsf_out_if.source           out_o,
  output crsf_pkg::back_sts_t  sts_o
);
  import crsf_pkg::*;

  logic pend_v_q, pv;
  idx_t pend_s_q, pend_e_q, ps, pe;
  seg_t out_q, spill_q, ea, eb, ef, r0, r1;
  logic out_v_q, spill_v_q, out_free;
  logic ea_v, eb_v;
  logic [1:0] n;

  always_comb begin
    pv   = pend_v_q;
    ps   = pend_s_q;
    pe   = pend_e_q;
    ea_v = 1'b0;
    eb_v = 1'b0;
    ea   = '{seg_start: pend_s_q, seg_end: pend_e_q, seg_valid: 1'b1, record_end: 1'b0};
    eb   = ea;
    ef   = '0;
    if (cmd_i.a_v) begin
      if (pv && (IdxW'(pe + 1'b1) == cmd_i.a_start)) begin
        pe = cmd_i.a_end;
      end else begin
        ea_v = pv;
        ea   = '{seg_start: ps, seg_end: pe, seg_valid: 1'b1, record_end: 1'b0};
        pv   = 1'b1;
        ps   = cmd_i.a_start;
        pe   = cmd_i.a_end;
      end
    end
    if (cmd_i.b_v) begin
      if (pv && (IdxW'(pe + 1'b1) == cmd_i.b_start)) begin
        pe = cmd_i.b_end;
      end else begin
        eb_v = pv;
        eb   = '{seg_start: ps, seg_end: pe, seg_valid: 1'b1, record_end: 1'b0};
        pv   = 1'b1;
        ps   = cmd_i.b_start;
        pe   = cmd_i.b_end;
      end
    end
    if (cmd_i.last) begin
      ef = pv ? '{seg_start: ps, seg_end: pe, seg_valid: 1'b1, record_end: 1'b1}
              : '{seg_start: '0, seg_end: '0, seg_valid: 1'b0, record_end: 1'b1};
      pv = 1'b0;
    end
    r1 = ef;
    if (ea_v) begin
      r0 = ea;
      r1 = eb_v ? eb : ef;
    end else if (eb_v) begin
      r0 = eb;
    end else begin
      r0 = ef;
    end
    n = 2'(ea_v) + 2'(eb_v) + 2'(cmd_i.last);
    if (n > 2'd2) begin
      n = 2'd2;
    end
  end

  assign out_free = !out_v_q || out_o.ready;
  assign pop_o    = q_valid_i && !spill_v_q && out_free;

  assign out_o.valid      = out_v_q;
  assign out_o.seg_start  = out_q.seg_start;
  assign out_o.seg_end    = out_q.seg_end;
  assign out_o.seg_valid  = out_q.seg_valid;
  assign out_o.record_end = out_q.record_end;
  assign sts_o            = '{out_v: out_v_q, spill_v: spill_v_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (pop_o) begin
      pend_v_q <= pv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pend_s_q <= ps;
      pend_e_q <= pe;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      spill_v_q <= 1'b0;
    end else if (spill_v_q) begin
      if (out_free) begin
        out_v_q   <= 1'b1;
        spill_v_q <= 1'b0;
      end
    end else if (pop_o) begin
      out_v_q   <= (n != 2'd0);
      spill_v_q <= (n == 2'd2);
    end else if (out_free) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (spill_v_q) begin
      if (out_free) begin
        out_q <= spill_q;
      end
    end else if (pop_o) begin
      out_q   <= r0;
      spill_q <= r1;
    end
  end

endmodule

/* src/constant_run_segment_finder.sv */
// Channel   Dir  Payload                                      Handshake
// in_i      in   sample_value[31:0] signed, last_sample       valid/ready
// out_o     out  seg_start[23:0], seg_end[23:0], seg_valid,    valid/ready
//                record_end
// cfg       in   cfg_wdata_i[15:0] = run_threshold            cfg_we_i
//
// One item per cycle sustained; the front run tracker takes a sample each cycle
// while the command queue has room. Results leave one per cycle from the output
// register while out_o is ready; a sample that flushes two results holds the back end
// until the second leaves the spill slot. Each command is registered in the queue first.
// Reset clears the run tracker, the queue and the held segment; threshold returns to 4.
// Output stalls back up through the queue to in_i.ready.
module constant_run_segment_finder #(
  parameter int unsigned SampleWidth = crsf_pkg::SampleWDef,
  parameter int unsigned QueueDepth  = crsf_pkg::QDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [crsf_pkg::ThrW-1:0] cfg_wdata_i,
  crsf_in_if.sink                   in_i,
  crsf_out_if.source                out_o
);
  import crsf_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            push_cmd, head_cmd;
  logic            push, q_full, q_valid, pop;
  logic [CntW-1:0] q_cnt;
  back_sts_t       back_sts;

  crsf_front #(.SampleWidth(SampleWidth)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  crsf_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .cnt_o  (q_cnt)
  );

  crsf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .cmd_i    (head_cmd),
    .pop_o    (pop),
    .out_o    (out_o),
    .sts_o    (back_sts)
  );

  a_empty_seg_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.seg_valid) |->
      (out_o.record_end && out_o.seg_start == '0 && out_o.seg_end == '0))
    else $error("empty segment result not a zeroed record end");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt <= CntW'(QueueDepth))
    else $error("command queue count beyond depth");

  a_spill_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_sts.spill_v |-> back_sts.out_v)
    else $error("spill slot holds a result while output register is empty");

  a_no_pop_while_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_sts.spill_v |-> !pop)
    else $error("command taken while second result still waits");

endmodule

/* tb/tb_constant_run_segment_finder.sv */
`timescale 1ns / 100ps

import crsf_pkg::*;

class segment_tracker;
  logic [ThrW-1:0] threshold;
  logic [31:0]     run_value;
  logic [ThrW-1:0] run_len;
  idx_t            run_first;
  idx_t            cur_idx;
  idx_t            held_start;
  idx_t            held_end;
  bit              held_valid;
  bit              new_record;
  seg_t            expected_segs[$];
  int unsigned     errors;
  int unsigned     results_seen;

  function new();
    threshold    = ThrReset;
    run_value    = '0;
    run_len      = '0;
    run_first    = '0;
    cur_idx      = '0;
    held_start   = '0;
    held_end     = '0;
    held_valid   = 1'b0;
    new_record   = 1'b1;
    errors       = 0;
    results_seen = 0;
  endfunction

  function void push_seg(idx_t s, idx_t e, logic v, logic r);
    seg_t t;
    t.seg_start  = s;
    t.seg_end    = e;
    t.seg_valid  = v;
    t.record_end = r;
    expected_segs.push_back(t);
  endfunction

  // merge into the held segment when adjacent, else release the held one
  function void offer_run(idx_t s, idx_t e);
    if (held_valid && idx_t'(held_end + 1) == s) begin
      held_end = e;
      return;
    end
    if (held_valid) push_seg(held_start, held_end, 1'b1, 1'b0);
    held_start = s;
    held_end   = e;
    held_valid = 1'b1;
  endfunction

  function void note_sample(logic [31:0] v, logic last);
    idx_t idx;
    if (new_record) begin
      idx        = '0;
      run_value  = v;
      run_len    = ThrW'(1);
      run_first  = '0;
      held_valid = 1'b0;
    end else begin
      idx = idx_t'(cur_idx + 1);
      if (v == run_value) begin
        if (run_len != RunMax) run_len = run_len + 1'b1;
      end else begin
        if (run_len >= threshold) offer_run(run_first, idx_t'(idx - 1));
        run_value = v;
        run_len   = ThrW'(1);
        run_first = idx;
      end
    end
    cur_idx    = idx;
    new_record = 1'b0;
    if (last) begin
      if (run_len >= threshold) offer_run(run_first, idx);
      if (held_valid) push_seg(held_start, held_end, 1'b1, 1'b1);
      else push_seg('0, '0, 1'b0, 1'b1);
      held_valid = 1'b0;
      new_record = 1'b1;
    end
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  task check_segment(seg_t got);
    seg_t want;
    results_seen++;
    if (expected_segs.size() == 0) begin
      report($sformatf("unexpected item start=%0d end=%0d valid=%0b rec_end=%0b",
                       got.seg_start, got.seg_end, got.seg_valid, got.record_end));
      return;
    end
    want = expected_segs.pop_front();
    if (got.seg_start !== want.seg_start)
      report($sformatf("seg_start got %0d want %0d", got.seg_start, want.seg_start));
    if (got.seg_end !== want.seg_end)
      report($sformatf("seg_end got %0d want %0d", got.seg_end, want.seg_end));
    if (got.seg_valid !== want.seg_valid)
      report($sformatf("seg_valid got %0b want %0b", got.seg_valid, want.seg_valid));
    if (got.record_end !== want.record_end)
      report($sformatf("record_end got %0b want %0b", got.record_end, want.record_end));
  endtask
endclass

module tb_constant_run_segment_finder;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned PhaseItems = 175;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [ThrW-1:0] cfg_wdata_i;
  bit              tx_idle;
  bit              rx_idle;
  int unsigned     quiet_cycles;
  int unsigned     phase_items;

  segment_tracker segs = new();

  crsf_in_if  in_bus();
  crsf_out_if out_bus();

  constant_run_segment_finder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    int unsigned r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_sample(input logic [31:0] v, input logic last);
    int unsigned gap;
    gap = tx_idle ? draw_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.sample_value <= v;
    in_bus.last_sample  <= last;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    segs.note_sample(v, last);
    phase_items++;
  endtask

  task automatic send_run(input logic [31:0] v, input int unsigned n, input bit close);
    for (int unsigned i = 0; i < n; i++) send_sample(v, close && (i == n - 1));
  endtask

  task automatic send_random_record(input int unsigned thr);
    logic [31:0] palette[3];
    int unsigned runs;
    int unsigned rl_max;
    int unsigned len;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 8);
      for (int unsigned i = 0; i < len; i++) send_sample($urandom, i == len - 1);
    end else begin
      for (int k = 0; k < 3; k++) palette[k] = $urandom;
      if ($urandom_range(0, 3) == 0) palette[1] = palette[0] ^ (32'h1 << $urandom_range(0, 31));
      rl_max = (thr == 0) ? 3 : ((thr > 8) ? 6 : thr + 2);
      runs   = $urandom_range(1, 6);
      for (int unsigned r = 0; r < runs; r++)
        send_run(palette[$urandom_range(0, 2)], $urandom_range(1, rl_max), r == runs - 1);
    end
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (segs.expected_segs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ThrW-1:0] v);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    segs.threshold  = v;
  endtask

  initial begin : rx_side
    int unsigned stall_left;
    bit          long_hold_done;
    seg_t        got;
    stall_left     = 0;
    long_hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        got.seg_start  = out_bus.seg_start;
        got.seg_end    = out_bus.seg_end;
        got.seg_valid  = out_bus.seg_valid;
        got.record_end = out_bus.record_end;
        segs.check_segment(got);
      end
      if (!long_hold_done && segs.results_seen >= 60) begin
        long_hold_done = 1'b1;
        stall_left     = LongHold;
      end else if (stall_left == 0 && rx_idle) begin
        stall_left = draw_gap();
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("constant_run_segment_finder regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [ThrW-1:0] thr_plan[10];
    thr_plan = '{16'd1, 16'd3, 16'd2, 16'hFFFF, 16'd5, 16'd4, 16'd8, 16'd2, 16'd1, 16'd6};
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= '0;
    in_bus.valid         <= 1'b0;
    in_bus.sample_value  <= '0;
    in_bus.last_sample   <= 1'b0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    phase_items = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_run(32'h7FFF_FFFF, 4, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'h8000_0000, 1'b1);

    write_threshold(16'd2);
    send_run(32'hFFFF_FFFF, 2, 1'b0);
    send_run(32'h0000_0000, 2, 1'b0);
    send_sample(32'h1234_5678, 1'b0);
    send_run(32'hA5A5_5A5A, 2, 1'b1);

    write_threshold(16'd0);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'h0000_0002, 1'b0);
    send_sample(32'h0000_0001, 1'b1);

    write_threshold(16'hFFFF);
    send_run(32'h0000_0003, 2, 1'b1);

    for (int p = 0; p < 10; p++) begin
      write_threshold(thr_plan[p]);
      tx_idle     = (p % 3) != 1;
      rx_idle     = (p % 3) != 2;
      phase_items = 0;
      while (phase_items < PhaseItems) send_random_record(thr_plan[p]);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (segs.errors == 0 && segs.expected_segs.size() == 0) begin
      $display("constant_run_segment_finder regression: pass");
    end else begin
      $display("constant_run_segment_finder regression: fail");
    end
    $finish;
  end

endmodule
